// File: rtl/led_mode_pwm_driver_top_assert.svh
// Assertion macros shared by the checker of the LED mode PWM driver.
// Needs nothing else; include it by its bare file name.
`ifndef LED_MODE_PWM_DRIVER_TOP_ASSERT_SVH
`define LED_MODE_PWM_DRIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LMPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("LED driver check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define LMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("LED driver check failed: next-cycle implication");

`endif

// File: rtl/lmpd_pkg.sv
// Package of the LED mode PWM driver: codes, widths, the result struct
// and the pin polarity helper. Depends on nothing.
`default_nettype none

package lmpd_pkg;

    localparam int LEVEL_W     = 8;
    localparam int MODE_W      = 3;
    localparam int ACTION_W    = 2;
    localparam int ACC_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = ACTION_W;
    localparam int OUT_TDATA_W = 16;

    localparam int BLINK_PERIOD = 100;
    localparam int BLINK_W      = $clog2(BLINK_PERIOD);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    localparam logic [CFG_DATA_W-1:0] SMOOTH_DELAY_RST = 8'd2;
    localparam logic                  ACTIVE_HIGH_RST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_DELAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH  = 1'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 2'd0,
        ACT_SET_MODE  = 2'd1,
        ACT_SET_LEVEL = 2'd2
    } t_action;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF            = 3'd0,
        MODE_ON             = 3'd1,
        MODE_SMOOTH_ON      = 3'd2,
        MODE_SMOOTH_OFF     = 3'd3,
        MODE_THROB          = 3'd4,
        MODE_BLINK          = 3'd5,
        MODE_MOMENTARY      = 3'd6,
        MODE_MOMENTARY_DOWN = 3'd7
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [LEVEL_W-1:0]  level;
        logic                pin;
    } t_result;

    // Electrical pin level for a wanted LED state under the given polarity.
    function automatic logic drive_pin(input logic lit, input logic active_high);
        return ~(lit ^ active_high);
    endfunction

endpackage

`default_nettype wire

// File: rtl/lmpd_core.sv
// State and next-state logic of the LED mode PWM driver: configuration
// registers, mode, intensity, phases and PWM accumulator. Uses lmpd_pkg.
`default_nettype none

module lmpd_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [lmpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lmpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_fire,
    input  logic [lmpd_pkg::ACTION_W-1:0]    i_action,
    input  logic [lmpd_pkg::MODE_W-1:0]      i_new_mode,
    input  logic [lmpd_pkg::LEVEL_W-1:0]     i_new_level,
    output lmpd_pkg::t_result                o_res
);
    import lmpd_pkg::*;

    logic [CFG_DATA_W-1:0] r_smooth_delay;
    logic                  r_active_high;

    t_mode                 r_mode,         n_mode;
    logic [LEVEL_W-1:0]    r_level,        n_level;
    logic                  r_rising,       n_rising;
    logic [ACC_W-1:0]      r_acc,          n_acc;
    logic [LEVEL_W-1:0]    r_delay_phase,  n_delay_phase;
    logic [BLINK_W-1:0]    r_blink_phase,  n_blink_phase;
    logic                  r_pin,          n_pin;

    logic [LEVEL_W-1:0]    sd_eff;
    logic [LEVEL_W:0]      dp_inc;
    logic [BLINK_W:0]      bp_inc;
    logic                  step;
    logic                  rising_t;
    logic                  is_blink;
    logic [ACC_W:0]        acc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_delay <= SMOOTH_DELAY_RST;
            r_active_high  <= ACTIVE_HIGH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SMOOTH_DELAY: r_smooth_delay <= i_cfg_data;
                REG_ACTIVE_HIGH:  r_active_high  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OFF;
            r_level       <= '0;
            r_rising      <= 1'b0;
            r_acc         <= '0;
            r_delay_phase <= '0;
            r_blink_phase <= '0;
            r_pin         <= 1'b0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_level       <= n_level;
            r_rising      <= n_rising;
            r_acc         <= n_acc;
            r_delay_phase <= n_delay_phase;
            r_blink_phase <= n_blink_phase;
            r_pin         <= n_pin;
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_level       = r_level;
        n_rising      = r_rising;
        n_acc         = r_acc;
        n_delay_phase = r_delay_phase;
        n_blink_phase = r_blink_phase;
        n_pin         = r_pin;

        // A smoothing delay of zero behaves as one.
        sd_eff   = (r_smooth_delay == '0) ? LEVEL_W'(1) : r_smooth_delay;
        dp_inc   = {1'b0, r_delay_phase} + (LEVEL_W+1)'(1);
        bp_inc   = {1'b0, r_blink_phase} + (BLINK_W+1)'(1);
        step     = 1'b0;
        rising_t = r_rising;
        is_blink = 1'b0;
        acc_sum  = '0;

        case (t_action'(i_action))
            ACT_TICK: begin
                n_delay_phase = (dp_inc >= {1'b0, sd_eff}) ? '0 : dp_inc[LEVEL_W-1:0];
                n_blink_phase = (bp_inc >= (BLINK_W+1)'(BLINK_PERIOD)) ? '0
                                                                      : bp_inc[BLINK_W-1:0];
                step = (n_delay_phase == '0);

                case (r_mode)
                    MODE_SMOOTH_ON: begin
                        if (r_level != LEVEL_MAX) n_level = r_level + LEVEL_W'(1);
                    end
                    MODE_SMOOTH_OFF: begin
                        if (r_level != '0 && step) n_level = r_level - LEVEL_W'(1);
                    end
                    MODE_THROB: begin
                        if (r_level == '0) rising_t = 1'b1;
                        else if (r_level == LEVEL_MAX) rising_t = 1'b0;
                        n_rising = rising_t;
                        if (step) begin
                            if (rising_t && r_level != LEVEL_MAX)
                                n_level = r_level + LEVEL_W'(1);
                            else if (!rising_t && r_level != '0)
                                n_level = r_level - LEVEL_W'(1);
                        end
                    end
                    MODE_BLINK: begin
                        is_blink = 1'b1;
                    end
                    MODE_MOMENTARY: begin
                        if (r_level == LEVEL_MAX) n_mode = MODE_MOMENTARY_DOWN;
                        else n_level = r_level + LEVEL_W'(1);
                    end
                    MODE_MOMENTARY_DOWN: begin
                        if (r_level == '0) n_mode = MODE_OFF;
                        else n_level = r_level - LEVEL_W'(1);
                    end
                    default: ;
                endcase

                if (is_blink) begin
                    // Dark for the first half of the period, lit for the second.
                    n_pin = drive_pin(n_blink_phase >= BLINK_W'(BLINK_PERIOD / 2),
                                      r_active_high);
                end else begin
                    acc_sum = {1'b0, r_acc} + {2'b00, n_level};
                    if (acc_sum >= (ACC_W+1)'(LEVEL_MAX)) begin
                        n_pin = drive_pin(1'b1, r_active_high);
                        n_acc = ACC_W'(acc_sum - (ACC_W+1)'(LEVEL_MAX));
                    end else begin
                        n_pin = drive_pin(1'b0, r_active_high);
                        n_acc = acc_sum[ACC_W-1:0];
                    end
                end
            end
            ACT_SET_MODE: begin
                n_mode = t_mode'(i_new_mode);
                case (t_mode'(i_new_mode))
                    MODE_OFF: begin
                        n_level = '0;
                        n_acc   = '0;
                    end
                    MODE_ON: begin
                        n_level = LEVEL_MAX;
                        n_acc   = '0;
                    end
                    MODE_THROB: begin
                        n_rising = (r_level == '0);
                    end
                    MODE_BLINK: begin
                        n_level = '0;
                    end
                    default: ;
                endcase
            end
            ACT_SET_LEVEL: begin
                n_level = i_new_level;
                n_acc   = '0;
            end
            default: ;
        endcase
    end

    assign o_res.mode  = n_mode;
    assign o_res.level = n_level;
    assign o_res.pin   = n_pin;

endmodule

`default_nettype wire

// File: rtl/lmpd_skid.sv
// Two-entry output buffer of the LED mode PWM driver: a result register
// and a skid register, with a registered ready. Uses lmpd_pkg.
`default_nettype none

module lmpd_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lmpd_pkg::t_result  i_res,
    output logic               o_valid,
    input  logic               i_ready,
    output lmpd_pkg::t_result  o_res
);
    import lmpd_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    in_fire;
    logic    out_fire;

    assign o_ready  = ~r_skid_valid;
    assign in_fire  = i_valid & ~r_skid_valid;
    assign out_fire = r_main_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_main_valid || out_fire) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) r_main <= r_skid;
        end else if (in_fire) begin
            if (!r_main_valid || out_fire) r_main <= i_res;
            else r_skid <= i_res;
        end
    end

    assign o_valid = r_main_valid;
    assign o_res   = r_main;

endmodule

`default_nettype wire

// File: rtl/led_mode_pwm_driver_top.sv
// Top level of the LED mode PWM driver: stream ports, configuration port,
// state core and output buffer. Uses lmpd_pkg, lmpd_core and lmpd_skid.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: action; tdata: mode, level
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: pin, level, mode
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// The state registers update at the edge that accepts an item, and its result
// is registered at that same edge, in the output register or the skid register.
// The rate is set by the state update, so one item per clock
// is sustained while results are taken.
// Reset is synchronous and active low; it restores the default registers.
// A stalled output fills the skid register, after which input ready drops.
//
// The block lights one LED pin. An item is a tick, a mode change or an
// intensity write; every item gives exactly one result carrying the pin
// level, the intensity and the mode after the item. On a tick the mode may
// ramp the intensity and the intensity is added into a PWM accumulator,
// lighting the pin whenever the sum reaches 255. Blink mode instead drives
// the pin from a fixed period counter. Configuration writes are always
// ready and are meant to land while the block is idle.
`default_nettype none

module led_mode_pwm_driver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lmpd_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // [1:0] action
    input  logic [lmpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [2:0] new_mode, [10:3] new_level
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lmpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [0] pin_level, [8:1] level_now,
                                                               // [11:9] mode_now
    // Configuration writes: index 0 smooth_delay, index 1 active_high.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lmpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lmpd_pkg::*;

    t_result core_res;
    t_result out_res;
    logic    in_fire;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = s_axis_tvalid & s_axis_tready;

    lmpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (in_fire),
        .i_action    (s_axis_tuser),
        .i_new_mode  (s_axis_tdata[MODE_W-1:0]),
        .i_new_level (s_axis_tdata[MODE_W+LEVEL_W-1:MODE_W]),
        .o_res       (core_res)
    );

    lmpd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_res   (core_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    // Pin level in the lowest bit, then intensity, then mode; zeros above.
    assign m_axis_tdata = {(OUT_TDATA_W - MODE_W - LEVEL_W - 1)'(0),
                           out_res.mode, out_res.level, out_res.pin};

endmodule

`default_nettype wire

// File: rtl/lmpd_checker.sv
// Port-level checker of the LED mode PWM driver and its bind statement.
// Uses lmpd_pkg and the macros of led_mode_pwm_driver_top_assert.svh.
`default_nettype none
`include "led_mode_pwm_driver_top_assert.svh"

module lmpd_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [lmpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import lmpd_pkg::*;

    logic                                   in_fire;
    logic                                   out_stall;
    logic [OUT_TDATA_W-MODE_W-LEVEL_W-2:0]  out_pad;

    assign in_fire   = s_axis_tvalid & s_axis_tready;
    assign out_stall = m_axis_tvalid & ~m_axis_tready;
    assign out_pad   = m_axis_tdata[OUT_TDATA_W-1:MODE_W+LEVEL_W+1];

    // A result that is not taken stays offered.
    `LMPD_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, out_stall, m_axis_tvalid)

    // An accepted item always leaves a result offered in the next cycle.
    `LMPD_ASSERT_NEXT(a_item_gives_result, i_clk, i_rst_n, in_fire, m_axis_tvalid)

    // Input ready only drops when both output registers are full.
    `LMPD_ASSERT_NOW(a_ready_low_means_full, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)

    // An item is held back only behind a result that is stalled.
    `LMPD_ASSERT_NEXT(a_ready_low_after_stall, i_clk, i_rst_n,
                      s_axis_tready && !out_stall, s_axis_tready)

    // The bits above the mode field of an offered result are zero.
    `LMPD_ASSERT_NOW(a_out_pad_zero, i_clk, i_rst_n, m_axis_tvalid, out_pad == '0)

endmodule

bind led_mode_pwm_driver_top lmpd_checker u_lmpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/tb_led_mode_pwm_driver_top.sv
// Self-checking testbench for the LED mode PWM driver: directed and random items
// against a behavioural mirror of the driver state, under random stalls on both sides.
// Depends on lmpd_pkg and led_mode_pwm_driver_top only.
`timescale 1ns / 100ps

module tb_led_mode_pwm_driver_top;

    import lmpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int RX_HOLD_CYCLES = 300;   // long output stall used to fill the block
    localparam int TAIL_CYCLES    = 10;
    localparam int PHASE_COUNT    = 6;
    localparam int ITEMS_PER_PHASE = 130;

    // Action code that the block does not know; it must hold its state.
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    // Mirror of the driver: its own copy of the registers and the LED state,
    // stepped once per accepted item, plus the results still due from the block.
    class led_driver_mirror;
        logic [CFG_DATA_W-1:0] smooth_delay;
        logic                  active_high;
        t_mode                 mode;
        logic [LEVEL_W-1:0]    level;
        logic                  rising;
        logic [ACC_W-1:0]      acc;
        logic [7:0]            delay_phase;
        logic [6:0]            blink_phase;
        logic                  pin;
        t_result               due_results[$];
        int                    mismatch_count;

        function new();
            smooth_delay   = SMOOTH_DELAY_RST;
            active_high    = ACTIVE_HIGH_RST;
            mode           = MODE_OFF;
            level          = '0;
            rising         = 1'b0;
            acc            = '0;
            delay_phase    = '0;
            blink_phase    = '0;
            pin            = 1'b0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_SMOOTH_DELAY) begin
                smooth_delay = val;
            end else if (idx == REG_ACTIVE_HIGH) begin
                active_high = val[0];
            end
        endfunction

        function logic pin_for(logic lit);
            return (lit == active_high) ? 1'b1 : 1'b0;
        endfunction

        function void enter_mode(t_mode m);
            mode = m;
            case (m)
                MODE_OFF: begin
                    level = '0;
                    acc   = '0;
                end
                MODE_ON: begin
                    level = LEVEL_MAX;
                    acc   = '0;
                end
                MODE_THROB: rising = (level == 0);
                MODE_BLINK: level = '0;
                default: ;
            endcase
        endfunction

        function void tick_led();
            int   span;
            int   sum;
            logic step;
            // A zero delay behaves as one: a step on every tick.
            span = (smooth_delay == 0) ? 1 : int'(smooth_delay);
            delay_phase = (int'(delay_phase) + 1 >= span) ? 8'd0 : delay_phase + 8'd1;
            blink_phase = (int'(blink_phase) + 1 >= BLINK_PERIOD) ? 7'd0 : blink_phase + 7'd1;
            step = (delay_phase == 0);
            case (mode)
                MODE_SMOOTH_ON: begin
                    if (level != LEVEL_MAX) level = level + 8'd1;
                end
                MODE_SMOOTH_OFF: begin
                    if (level != 0 && step) level = level - 8'd1;
                end
                MODE_THROB: begin
                    if (level == 0) rising = 1'b1;
                    else if (level == LEVEL_MAX) rising = 1'b0;
                    if (step) begin
                        if (rising) begin
                            if (level != LEVEL_MAX) level = level + 8'd1;
                        end else begin
                            if (level != 0) level = level - 8'd1;
                        end
                    end
                end
                MODE_BLINK: begin
                    // Blink drives the pin from the period counter and leaves
                    // the accumulator alone.
                    pin = pin_for(blink_phase >= BLINK_PERIOD / 2);
                    return;
                end
                MODE_MOMENTARY: begin
                    if (level == LEVEL_MAX) mode = MODE_MOMENTARY_DOWN;
                    else level = level + 8'd1;
                end
                MODE_MOMENTARY_DOWN: begin
                    if (level == 0) mode = MODE_OFF;
                    else level = level - 8'd1;
                end
                default: ;
            endcase
            sum = int'(acc) + int'(level);
            if (sum >= int'(LEVEL_MAX)) begin
                pin = pin_for(1'b1);
                sum = sum - int'(LEVEL_MAX);
            end else begin
                pin = pin_for(1'b0);
            end
            acc = ACC_W'(sum);
        endfunction

        function void note_item(logic [ACTION_W-1:0] act, logic [MODE_W-1:0] m,
                                logic [LEVEL_W-1:0] lvl);
            t_result r;
            case (act)
                ACT_TICK:     tick_led();
                ACT_SET_MODE: enter_mode(t_mode'(m));
                ACT_SET_LEVEL: begin
                    level = lvl;
                    acc   = '0;
                end
                default: ;  // unknown action: state is held
            endcase
            r.pin   = pin;
            r.level = level;
            r.mode  = mode;
            due_results.push_back(r);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            t_result got;
            t_result want;
            got = t_result'(data[$bits(t_result)-1:0]);
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%h", data));
            end else begin
                want = due_results.pop_front();
                if (got.pin !== want.pin)
                    report_mismatch($sformatf("pin_level %b, expected %b", got.pin, want.pin));
                if (got.level !== want.level)
                    report_mismatch($sformatf("level_now %0d, expected %0d",
                                              got.level, want.level));
                if (got.mode !== want.mode)
                    report_mismatch($sformatf("mode_now %0d, expected %0d",
                                              got.mode, want.mode));
            end
        endtask
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // [1:0] action
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [2:0] new_mode, [10:3] new_level
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] pin_level, [8:1] level_now,
                                                 // [11:9] mode_now
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    led_driver_mirror mirror = new();

    // Idling knobs, changed between phases by the stimulus process.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    led_mode_pwm_driver_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver. Normally it stalls at random by the current percentage; when a
    // long hold is requested it keeps tready low for a fixed count of cycles,
    // counted here, so that the output register and skid fill and the block
    // has to drop its input ready while the sender keeps offering items.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                rx_hold_req = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Results are taken at the edge where both tvalid and tready are high.
    // Values read here are those from before the edge, as all drivers use
    // nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mirror.check_result(m_axis_tdata);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, idling first at the current sender percentage, and
    // returns at the edge that accepts it. tvalid is left high so that
    // back-to-back items need only one assignment per time step.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [MODE_W-1:0] m,
                             input logic [LEVEL_W-1:0] lvl);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(IN_TDATA_W - MODE_W - LEVEL_W){1'b0}}, lvl, m};
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.note_item(act, m, lvl);
        items_sent++;
    endtask

    // Stops offering and waits until every due result has been taken. It
    // always waits on the clock first, so a following item never re-raises tvalid in
    // the step where it was lowered.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (mirror.pending() != 0);
    endtask

    // Writes both registers back to back; only called while the block is idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] delay, input logic polarity);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SMOOTH_DELAY;
        i_cfg_data  <= delay;
        do @(posedge i_clk); while (!o_cfg_ready);
        mirror.write_reg(REG_SMOOTH_DELAY, delay);
        i_cfg_index <= REG_ACTIVE_HIGH;
        i_cfg_data  <= {{(CFG_DATA_W - 1){1'b0}}, polarity};
        do @(posedge i_clk); while (!o_cfg_ready);
        mirror.write_reg(REG_ACTIVE_HIGH, {{(CFG_DATA_W - 1){1'b0}}, polarity});
        i_cfg_valid <= 1'b0;
    endtask

    // Intensities lean towards both ends, where ramps turn, saturate or stop.
    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(3));
            1:       return LEVEL_MAX - 8'($urandom_range(3));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        return 3'($urandom_range(7));
    endfunction

    // One well-formed sequence: an optional intensity write, a mode change and
    // a run of ticks, sprinkled with stray writes, mode changes and items of
    // the unknown action. Fields an action does not use carry random bits.
    task automatic run_sequence();
        int ticks;
        int roll;
        if ($urandom_range(99) < 60)
            send_item(ACT_SET_LEVEL, pick_mode(), pick_level());
        send_item(ACT_SET_MODE, pick_mode(), 8'($urandom_range(255)));
        // Mostly short runs; now and then one long enough for a full
        // momentary rise or a blink period.
        ticks = ($urandom_range(9) == 0) ? $urandom_range(300, 60) : $urandom_range(40, 1);
        repeat (ticks) begin
            roll = $urandom_range(99);
            if (roll < 4)
                send_item(ACT_SET_LEVEL, pick_mode(), pick_level());
            else if (roll < 6)
                send_item(ACT_SET_MODE, pick_mode(), 8'($urandom_range(255)));
            else if (roll < 8)
                send_item(ACT_UNKNOWN, pick_mode(), 8'($urandom_range(255)));
            else
                send_item(ACT_TICK, pick_mode(), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        // Per phase: smooth delay (negative picks one at random), polarity,
        // sender idle and receiver stall percentages. The first phase runs at
        // the largest delay so that the lowered delay of the next one starts
        // below a phase counter that has already gone past it.
        int  delay_tab[PHASE_COUNT] = '{255, 3, 0, 1, -1, 2};
        int  polar_tab[PHASE_COUNT] = '{1, 0, 0, 1, -1, 1};
        int  tx_tab[PHASE_COUNT]    = '{0, 57, 0, 33, 0, 33};
        int  rx_tab[PHASE_COUNT]    = '{0, 0, 57, 33, 0, 33};
        int  phase_start;
        bit  held;
        bit  paused;
        logic [CFG_DATA_W-1:0] delay;
        logic polarity;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset settings (delay 2, active high).
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_SET_LEVEL, 3'd0, LEVEL_MAX);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_SET_MODE, MODE_ON, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_SET_MODE, MODE_OFF, 8'd0);
        // Smooth on saturates at full intensity.
        send_item(ACT_SET_MODE, MODE_SMOOTH_ON, 8'd0);
        send_item(ACT_SET_LEVEL, 3'd0, 8'd254);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        // Smooth off stops at zero.
        send_item(ACT_SET_MODE, MODE_SMOOTH_OFF, 8'd0);
        send_item(ACT_SET_LEVEL, 3'd0, 8'd1);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        // Throb entered from dark rises, from full falls.
        send_item(ACT_SET_MODE, MODE_THROB, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_SET_LEVEL, 3'd0, LEVEL_MAX);
        send_item(ACT_SET_MODE, MODE_THROB, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_SET_MODE, MODE_BLINK, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        // Momentary turns down at full, and momentary down drops to off at zero.
        send_item(ACT_SET_LEVEL, 3'd0, 8'd254);
        send_item(ACT_SET_MODE, MODE_MOMENTARY, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_SET_LEVEL, 3'd0, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        // Unknown action with every field bit set: the state must be held.
        send_item(ACT_UNKNOWN, 3'b111, 8'hFF);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // Every item gives one result, so an empty store means the block
            // is idle; a few more cycles cover the output register.
            drain_results();
            repeat (4) @(posedge i_clk);
            delay    = (delay_tab[p] < 0) ? 8'($urandom_range(255, 1)) : 8'(delay_tab[p]);
            polarity = (polar_tab[p] < 0) ? 1'($urandom_range(1)) : 1'(polar_tab[p]);
            configure(delay, polarity);
            tx_idle_pct  = tx_tab[p];
            rx_stall_pct = rx_tab[p];
            phase_start  = items_sent;
            held         = 1'b0;
            paused       = 1'b0;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                // Back pressure in phase 4, which has no random idling: first a long
                // output stall while items keep coming, later a full drain.
                if (p == 4 && !held) begin
                    rx_hold_req = 1'b1;
                    held = 1'b1;
                end
                if (p == 4 && !paused && items_sent - phase_start >= 60) begin
                    drain_results();
                    paused = 1'b1;
                end
                run_sequence();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.pending() != 0)
            mirror.report_mismatch($sformatf("%0d results never arrived", mirror.pending()));
        if (mirror.mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
